[rtl/core/stack_asm_tokenizer_unit_assert.svh]
// Assertion macros shared by the tokenizer RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef STACK_ASM_TOKENIZER_UNIT_ASSERT_SVH
`define STACK_ASM_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SATOK_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tokenizer assertion violated");

// Next-cycle implication, disabled during reset.
`define SATOK_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tokenizer assertion violated");

`endif

[rtl/core/satok_pkg.sv]
// Shared types, constants and the keyword table of the tokenizer.
// No dependencies; imported by every tokenizer module.
package satok_pkg;

  localparam int MAX_LEXEME_DEF  = 24;
  localparam int OFFSET_BITS_DEF = 20;
  localparam int LINE_BITS_DEF   = 16;

  // fixed field widths of a result
  localparam int TYPE_W = 5;
  localparam int LEN_W  = 5;
  localparam int ERR_W  = 2;

  localparam int KW_CHARS   = 5;   // longest keyword
  localparam int KW_COUNT   = 23;
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [7:0] {
    MODE_IDLE       = 8'b0000_0001,
    MODE_INT        = 8'b0000_0010,
    MODE_FLOAT      = 8'b0000_0100,
    MODE_WORD       = 8'b0000_1000,
    MODE_CHAR_OPEN  = 8'b0001_0000,
    MODE_CHAR_CLOSE = 8'b0010_0000,
    MODE_COMMENT    = 8'b0100_0000,
    MODE_ERROR      = 8'b1000_0000
  } mode_t;

  localparam logic [TYPE_W-1:0] KIND_NONE    = 5'd0;
  localparam logic [TYPE_W-1:0] KIND_INT     = 5'd22;
  localparam logic [TYPE_W-1:0] KIND_REAL    = 5'd23;
  localparam logic [TYPE_W-1:0] KIND_LITERAL = 5'd24;
  localparam logic [TYPE_W-1:0] KIND_DEF     = 5'd26;
  localparam logic [TYPE_W-1:0] KIND_REF     = 5'd27;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNTERM   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef logic [KW_CHARS-1:0][7:0] prefix_t;

  typedef struct packed {
    logic              hit;
    logic [TYPE_W-1:0] code;
  } kw_hit_t;

  // output queue write request: second implies first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // keyword text, first character in the top byte, zero padded
  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
    {"nop", 16'h0}, {"push", 8'h0}, {"pop", 16'h0}, {"add", 16'h0},
    {"sub", 16'h0}, {"mul", 16'h0}, {"div", 16'h0}, {"mod", 16'h0},
    {"dup", 16'h0}, {"swap", 8'h0}, {"dup2", 8'h0}, "swap2",
    {"cmpe", 8'h0}, "cmpne", {"cmpg", 8'h0}, {"cmpl", 8'h0},
    "cmple", "cmpge", {"jmp", 16'h0}, {"jz", 24'h0},
    {"jnz", 16'h0}, "print", {"halt", 8'h0}
  };

  localparam logic [TYPE_W-1:0] KW_CODE [KW_COUNT] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
    5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd25
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Parallel match of the word prefix against all keywords.
  // len is the word length when fits is set; bytes past len are masked off.
  function automatic kw_hit_t kw_lookup(input prefix_t p, input logic [2:0] len,
                                        input logic fits);
    logic [KW_CHARS*8-1:0] key;
    kw_hit_t               r;
    key = '0;
    r   = '0;
    for (int j = 0; j < KW_CHARS; j++) begin
      if (3'(j) < len) key[(KW_CHARS-1-j)*8 +: 8] = p[j];
    end
    for (int i = 0; i < KW_COUNT; i++) begin
      if (fits && (key == KW_TEXT[i])) begin
        r.hit  = 1'b1;
        r.code = KW_CODE[i];
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/satok_scan.sv]
// Scanner: lexer state registers and the one-byte step logic.
// Depends on satok_pkg and the assertion macro header.
`include "stack_asm_tokenizer_unit_assert.svh"

module satok_scan
  import satok_pkg::*;
#(
  parameter int MAX_LEXEME  = MAX_LEXEME_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  localparam int RES_W = TYPE_W + LINE_BITS + OFFSET_BITS + LEN_W + ERR_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,   // byte transaction accepted
  input  logic [7:0]       ch,
  input  logic             eos,
  output push_t            push,
  output logic [RES_W-1:0] res0,
  output logic [RES_W-1:0] res1
);

  localparam int WLEN_W = $clog2(MAX_LEXEME + 1);

  mode_t                   mode, mode_mid, mode_next;
  logic [LINE_BITS-1:0]    line_count, line_mid, line_next, line_inc;
  logic [OFFSET_BITS-1:0]  byte_offset, offset_next;
  logic [OFFSET_BITS-1:0]  token_begin, tbeg_mid;
  logic [WLEN_W-1:0]       word_length, wlen_mid;
  prefix_t                 word_prefix, prefix_mid;

  logic                    grow, to_float, rescan, old_fits, mid_fits;
  kw_hit_t                 kw_old, kw_mid;

  logic                    a_v, b_v;
  logic [TYPE_W-1:0]       a_type, b_type;
  logic [OFFSET_BITS-1:0]  a_start, b_start;
  logic [WLEN_W-1:0]       a_len, b_len;
  logic [ERR_W-1:0]        a_err, b_err;
  logic [RES_W-1:0]        pack_a, pack_b;

  function automatic logic [RES_W-1:0] pack_res(
    input logic [TYPE_W-1:0] t, input logic [LINE_BITS-1:0] ln,
    input logic [OFFSET_BITS-1:0] st, input logic [WLEN_W-1:0] len,
    input logic [ERR_W-1:0] e, input logic last);
    return {last, e, LEN_W'(len), st, ln, t};
  endfunction

  assign line_inc = (line_count == '1) ? line_count : line_count + LINE_BITS'(1);
  assign old_fits = word_length <= WLEN_W'(KW_CHARS);
  assign kw_old   = kw_lookup(word_prefix, word_length[2:0], old_fits);
  assign mid_fits = wlen_mid <= WLEN_W'(KW_CHARS);
  assign kw_mid   = kw_lookup(prefix_mid, wlen_mid[2:0], mid_fits);

  // scan the byte in the current mode
  always_comb begin
    mode_mid   = mode;
    line_mid   = line_count;
    tbeg_mid   = token_begin;
    wlen_mid   = word_length;
    prefix_mid = word_prefix;
    grow       = 1'b0;
    to_float   = 1'b0;
    rescan     = 1'b0;
    a_v        = 1'b0;
    a_type     = KIND_NONE;
    a_start    = token_begin;
    a_len      = word_length;
    a_err      = ERR_NONE;

    unique case (mode)
      MODE_INT: begin
        if (is_digit(ch)) begin
          grow = 1'b1;
        end else if (ch == CH_DOT) begin
          grow     = 1'b1;
          to_float = 1'b1;
        end else begin
          a_v    = 1'b1;
          a_type = KIND_INT;
          rescan = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (is_digit(ch)) begin
          grow = 1'b1;
        end else begin
          a_v    = 1'b1;
          a_type = KIND_REAL;
          rescan = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_digit(ch) || is_alpha(ch)) begin
          grow = 1'b1;
        end else if (!kw_old.hit && (ch == CH_COLON)) begin
          a_v      = 1'b1;
          a_type   = KIND_DEF;
          mode_mid = MODE_IDLE;
        end else begin
          a_v    = 1'b1;
          a_type = kw_old.hit ? kw_old.code : KIND_REF;
          rescan = 1'b1;
        end
      end
      MODE_CHAR_OPEN: begin
        a_v      = 1'b1;
        a_type   = KIND_LITERAL;
        a_start  = token_begin + OFFSET_BITS'(1);
        a_len    = WLEN_W'(1);
        mode_mid = MODE_CHAR_CLOSE;
      end
      MODE_CHAR_CLOSE: begin
        if (ch == CH_QUOTE) begin
          mode_mid = MODE_IDLE;
        end else begin
          a_v      = 1'b1;
          a_len    = '0;
          a_err    = ERR_UNTERM;
          mode_mid = MODE_ERROR;
        end
      end
      MODE_COMMENT: begin
        if (ch == CH_NL) begin
          line_mid = line_inc;
          mode_mid = MODE_IDLE;
        end
      end
      MODE_IDLE:  rescan = 1'b1;
      MODE_ERROR: ;
      default:    ;
    endcase

    if (grow) begin
      if (word_length >= WLEN_W'(MAX_LEXEME)) begin
        a_v      = 1'b1;
        a_type   = KIND_NONE;
        a_len    = '0;
        a_err    = ERR_TOO_LONG;
        mode_mid = MODE_ERROR;
      end else begin
        if (word_length < WLEN_W'(KW_CHARS)) prefix_mid[word_length[2:0]] = ch;
        wlen_mid = word_length + WLEN_W'(1);
        if (to_float) mode_mid = MODE_FLOAT;
      end
    end

    // byte ends a token or arrives idle: it may start a new lexeme
    if (rescan) begin
      mode_mid = MODE_IDLE;
      tbeg_mid = byte_offset;
      if (ch == CH_NL) begin
        line_mid = line_inc;
      end else if (is_digit(ch)) begin
        mode_mid = MODE_INT;
        wlen_mid = WLEN_W'(1);
      end else if (is_alpha(ch)) begin
        mode_mid      = MODE_WORD;
        prefix_mid[0] = ch;
        wlen_mid      = WLEN_W'(1);
      end else if (ch == CH_QUOTE) begin
        mode_mid = MODE_CHAR_OPEN;
      end else if (ch == CH_HASH) begin
        mode_mid = MODE_COMMENT;
      end
    end
  end

  // end-of-source flush
  always_comb begin
    b_v         = 1'b0;
    b_type      = KIND_NONE;
    b_start     = tbeg_mid;
    b_len       = wlen_mid;
    b_err       = ERR_NONE;
    mode_next   = mode_mid;
    line_next   = line_mid;
    offset_next = byte_offset + OFFSET_BITS'(1);
    if (eos && (mode_mid != MODE_ERROR)) begin
      mode_next   = MODE_IDLE;
      line_next   = LINE_BITS'(1);
      offset_next = '0;
      unique case (mode_mid) inside
        MODE_INT: begin
          b_v    = 1'b1;
          b_type = KIND_INT;
        end
        MODE_FLOAT: begin
          b_v    = 1'b1;
          b_type = KIND_REAL;
        end
        MODE_WORD: begin
          b_v    = 1'b1;
          b_type = kw_mid.hit ? kw_mid.code : KIND_REF;
        end
        MODE_CHAR_OPEN, MODE_CHAR_CLOSE: begin
          b_v       = 1'b1;
          b_len     = '0;
          b_err     = ERR_UNTERM;
          mode_next = MODE_ERROR;
        end
        default: ;
      endcase
    end
  end

  assign pack_a = pack_res(a_type, line_count, a_start, a_len, a_err, !b_v);
  assign pack_b = pack_res(b_type, line_mid, b_start, b_len, b_err, 1'b1);

  assign push.first  = step && (a_v || b_v);
  assign push.second = step && a_v && b_v;
  assign res0        = a_v ? pack_a : pack_b;
  assign res1        = pack_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      line_count  <= LINE_BITS'(1);
      byte_offset <= '0;
      token_begin <= '0;
      word_length <= '0;
    end else if (step) begin
      mode        <= mode_next;
      line_count  <= line_next;
      byte_offset <= offset_next;
      token_begin <= tbeg_mid;
      word_length <= wlen_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) word_prefix <= prefix_mid;
  end

  `SATOK_ASSERT_NEXT(a_error_sticky, clk, rst, mode == MODE_ERROR, mode == MODE_ERROR)
  `SATOK_ASSERT_NOW(a_error_silent, clk, rst, mode == MODE_ERROR, !push.first)

endmodule

[rtl/core/satok_out_fifo.sv]
// Result queue between the scanner and the output stream; takes up to two results per
// cycle and hands out one while take is high. Depends on satok_pkg and the assertion macro header.
`include "stack_asm_tokenizer_unit_assert.svh"

module satok_out_fifo
  import satok_pkg::*;
#(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             room,    // at least two free entries
  output logic             valid,
  input  logic             take,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  logic [WIDTH-1:0] q [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] n_in;
  logic             pop;

  assign pop        = valid && take;
  assign n_in       = push.second ? CNT_W'(2) : (push.first ? CNT_W'(1) : '0);
  assign count_next = count + n_in - CNT_W'(pop);
  assign room       = count <= CNT_W'(OUTQ_DEPTH - 2);
  assign valid      = count != '0;
  assign dout       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_in);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first)  q[wr_ptr] <= din0;
    if (push.second) q[wr_ptr + PTR_W'(1)] <= din1;
  end

  `SATOK_ASSERT_NOW(a_push_has_room, clk, rst, push.first, count <= CNT_W'(OUTQ_DEPTH - 2))
  `SATOK_ASSERT_NOW(a_second_needs_first, clk, rst, push.second, push.first)
  `SATOK_ASSERT_NEXT(a_count_tracks, clk, rst, push.second && !pop, count == $past(count) + CNT_W'(2))

endmodule

[rtl/core/stack_asm_tokenizer_unit.sv]
// Tokenizer for a small stack-machine assembly language, top level.
// Depends on satok_pkg, satok_scan and satok_out_fifo.
//
// Source text enters one byte per transaction on the s_ side (s_tlast marks the final byte
// of a text) and tokens leave on the m_ side, one per transaction. Each token carries its
// kind (opcode 0..21, int 22, float 23, char 24, halt 25, label 26, label ref 27), line,
// start offset, length and an error code; m_tlast marks the last token caused by one input
// byte. A byte is scanned in the cycle it is accepted: the scanner state registers and the
// keyword match (a parallel compare against a constant 23-entry table) form a single
// registered pass, so one byte per clock is taken while s_tready is high. Most bytes make
// zero or one token; a byte that both ends a token and closes the text makes two, both
// queued at once. Tokens wait in a 4-entry queue; s_tready drops while fewer than two entries
// are free, so input stalls only when the downstream side holds results back. After an error
// token (unterminated char literal, or a number or word longer than MAX_LEXEME bytes) the
// unit accepts bytes but stays silent until rst. No clearing pass is needed after reset.
// Line numbers saturate; offsets wrap. Line and offset restart after s_tlast.

module stack_asm_tokenizer_unit
  import satok_pkg::*;
#(
  parameter int MAX_LEXEME  = MAX_LEXEME_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  localparam int OUT_BITS = TYPE_W + LINE_BITS + OFFSET_BITS + LEN_W + ERR_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // ch[7:0]
  input  logic             s_tlast,   // end_of_source
  output logic             m_tvalid,
  input  logic             m_tready,
  // token_type, line_number, lexeme_start, lexeme_length, error_code, zero pad on top
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast    // last_of_run
);

  localparam int RES_W = OUT_BITS + 1;   // result plus its last-of-run flag

  logic             step;
  push_t            push;
  logic [RES_W-1:0] res0, res1, head;

  // a byte transaction completes here
  assign step = s_tvalid && s_tready;

  satok_scan #(
    .MAX_LEXEME  (MAX_LEXEME),
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (s_tdata),
    .eos  (s_tlast),
    .push (push),
    .res0 (res0),
    .res1 (res1)
  );

  // queue decouples the two sides: ready depends only on its registered fill level
  satok_out_fifo #(
    .WIDTH (RES_W)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din0  (res0),
    .din1  (res1),
    .room  (s_tready),
    .valid (m_tvalid),
    .take  (m_tready),
    .dout  (head)
  );

  assign m_tdata = OUT_W'(head[OUT_BITS-1:0]);
  assign m_tlast = head[OUT_BITS];

endmodule

[dv/tokenizer_checker.sv]
`timescale 1ns / 100ps
// Token checker for stack_asm_tokenizer_unit: predicts the tokens of every accepted source byte
// and compares each output transaction, field by field, with the oldest prediction.
// Depends on satok_pkg for widths, scan modes, token kinds, error codes and character codes.
module tokenizer_checker
  import satok_pkg::*;
#(
  localparam int TOK_W = ((TYPE_W + LINE_BITS_DEF + OFFSET_BITS_DEF + LEN_W + ERR_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [TOK_W-1:0] m_tdata,
  input  logic             m_tlast,
  output int               mismatches,
  output int               outstanding
);

  localparam int LINE_LSB  = TYPE_W;
  localparam int START_LSB = LINE_LSB + LINE_BITS_DEF;
  localparam int LEN_LSB   = START_LSB + OFFSET_BITS_DEF;
  localparam int ERR_LSB   = LEN_LSB + LEN_W;

  typedef enum logic [TYPE_W-1:0] {
    OP_NOP = 5'd0, OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DUP, OP_SWAP,
    OP_DUP2, OP_SWAP2, OP_CMPE, OP_CMPNE, OP_CMPG, OP_CMPL, OP_CMPLE, OP_CMPGE, OP_JMP,
    OP_JZ, OP_JNZ, OP_PRINT, OP_HALT = 5'd25
  } opcode_t;

  typedef struct packed {
    logic [TYPE_W-1:0]          kind;
    logic [LINE_BITS_DEF-1:0]   line;
    logic [OFFSET_BITS_DEF-1:0] start;
    logic [LEN_W-1:0]           len;
    logic [ERR_W-1:0]           err;
    logic                       last;
  } token_t;

  // lexer state as seen from outside
  mode_t                      scan;
  logic [LINE_BITS_DEF-1:0]   line_no;
  logic [OFFSET_BITS_DEF-1:0] offset;
  logic [OFFSET_BITS_DEF-1:0] lex_begin;
  logic [LEN_W-1:0]           lex_len;
  logic [7:0]                 head [KW_CHARS];

  token_t  byte_tokens[$];   // tokens of the byte being scanned
  token_t  tokens_due[$];    // predicted, not yet seen on the output
  opcode_t opcodes[string];
  int      token_idx;

  initial begin
    opcodes["nop"]   = OP_NOP;   opcodes["push"]  = OP_PUSH;  opcodes["pop"]   = OP_POP;
    opcodes["add"]   = OP_ADD;   opcodes["sub"]   = OP_SUB;   opcodes["mul"]   = OP_MUL;
    opcodes["div"]   = OP_DIV;   opcodes["mod"]   = OP_MOD;   opcodes["dup"]   = OP_DUP;
    opcodes["swap"]  = OP_SWAP;  opcodes["dup2"]  = OP_DUP2;  opcodes["swap2"] = OP_SWAP2;
    opcodes["cmpe"]  = OP_CMPE;  opcodes["cmpne"] = OP_CMPNE; opcodes["cmpg"]  = OP_CMPG;
    opcodes["cmpl"]  = OP_CMPL;  opcodes["cmple"] = OP_CMPLE; opcodes["cmpge"] = OP_CMPGE;
    opcodes["jmp"]   = OP_JMP;   opcodes["jz"]    = OP_JZ;    opcodes["jnz"]   = OP_JNZ;
    opcodes["print"] = OP_PRINT; opcodes["halt"]  = OP_HALT;
  end

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // only words of keyword size can match; the compare is case-sensitive
  function automatic logic keyword_hit(output logic [TYPE_W-1:0] code);
    string word;
    word = "";
    code = KIND_NONE;
    if (lex_len > KW_CHARS) return 1'b0;
    for (int j = 0; j < lex_len; j++) word = $sformatf("%s%c", word, head[j]);
    if (!opcodes.exists(word)) return 1'b0;
    code = opcodes[word];
    return 1'b1;
  endfunction

  function automatic void put(input logic [TYPE_W-1:0] kind,
                              input logic [OFFSET_BITS_DEF-1:0] start,
                              input logic [LEN_W-1:0] len, input logic [ERR_W-1:0] err);
    token_t t;
    t = '{kind, line_no, start, len, err, 1'b0};
    byte_tokens.push_back(t);
  endfunction

  // error token, then silence for good
  function automatic void abort(input logic [ERR_W-1:0] err);
    put(KIND_NONE, lex_begin, '0, err);
    scan = MODE_ERROR;
  endfunction

  function automatic logic extend(input logic [7:0] c);
    if (lex_len >= MAX_LEXEME_DEF) begin
      abort(ERR_TOO_LONG);
      return 1'b0;
    end
    if (lex_len < KW_CHARS) head[lex_len] = c;
    lex_len++;
    return 1'b1;
  endfunction

  function automatic void next_line();
    if (line_no != '1) line_no++;
  endfunction

  function automatic void emit_word();
    logic [TYPE_W-1:0] code;
    logic              hit;
    hit = keyword_hit(code);
    put(hit ? code : KIND_REF, lex_begin, lex_len, ERR_NONE);
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic [TYPE_W-1:0] code;
    logic              restart;
    restart = 1'b0;
    case (scan)
      MODE_INT: begin
        if (is_num(c)) void'(extend(c));
        else if (c == CH_DOT) begin
          if (extend(c)) scan = MODE_FLOAT;
        end else begin
          put(KIND_INT, lex_begin, lex_len, ERR_NONE);
          restart = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (is_num(c)) void'(extend(c));
        else begin
          put(KIND_REAL, lex_begin, lex_len, ERR_NONE);
          restart = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_num(c) || is_letter(c)) void'(extend(c));
        else if (!keyword_hit(code) && c == CH_COLON) begin
          // label definition swallows its colon
          put(KIND_DEF, lex_begin, lex_len, ERR_NONE);
          scan = MODE_IDLE;
        end else begin
          emit_word();
          restart = 1'b1;
        end
      end
      MODE_CHAR_OPEN: begin
        // any byte is the literal, newline too, without counting a line
        put(KIND_LITERAL, lex_begin + 1'b1, LEN_W'(1), ERR_NONE);
        scan = MODE_CHAR_CLOSE;
      end
      MODE_CHAR_CLOSE: begin
        if (c == CH_QUOTE) scan = MODE_IDLE;
        else abort(ERR_UNTERM);
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          next_line();
          scan = MODE_IDLE;
        end
      end
      MODE_IDLE: restart = 1'b1;
      default: ;
    endcase
    // the byte that ended a token is scanned again from idle
    if (restart) begin
      scan      = MODE_IDLE;
      lex_begin = offset;
      if (c == CH_NL) next_line();
      else if (is_num(c)) begin
        scan    = MODE_INT;
        lex_len = 1;
      end else if (is_letter(c)) begin
        scan    = MODE_WORD;
        head[0] = c;
        lex_len = 1;
      end else if (c == CH_QUOTE) scan = MODE_CHAR_OPEN;
      else if (c == CH_HASH) scan = MODE_COMMENT;
    end
  endfunction

  // end of text: pending token out, open literal is an error, open comment just ends
  function automatic void close_text();
    case (scan) inside
      MODE_INT:   put(KIND_INT, lex_begin, lex_len, ERR_NONE);
      MODE_FLOAT: put(KIND_REAL, lex_begin, lex_len, ERR_NONE);
      MODE_WORD:  emit_word();
      MODE_CHAR_OPEN, MODE_CHAR_CLOSE: abort(ERR_UNTERM);
      default: ;
    endcase
    if (scan != MODE_ERROR) scan = MODE_IDLE;
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic text_end);
    if (scan == MODE_ERROR) return;
    byte_tokens.delete();
    scan_byte(c);
    if (text_end && scan != MODE_ERROR) begin
      close_text();
      if (scan != MODE_ERROR) begin
        line_no = 1;
        offset  = '0;
      end
    end else begin
      offset++;
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("tokenizer: transaction %0d %s: got 0x%0h, expected 0x%0h",
             token_idx, what, got, want);
    mismatches++;
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report("token with none predicted", 64'(m_tdata), '0);
      token_idx++;
      return;
    end
    want = tokens_due.pop_front();
    if (m_tdata[0 +: TYPE_W] != want.kind) report("token_type", m_tdata[0 +: TYPE_W], want.kind);
    if (m_tdata[LINE_LSB +: LINE_BITS_DEF] != want.line)
      report("line_number", m_tdata[LINE_LSB +: LINE_BITS_DEF], want.line);
    if (m_tdata[START_LSB +: OFFSET_BITS_DEF] != want.start)
      report("lexeme_start", m_tdata[START_LSB +: OFFSET_BITS_DEF], want.start);
    if (m_tdata[LEN_LSB +: LEN_W] != want.len)
      report("lexeme_length", m_tdata[LEN_LSB +: LEN_W], want.len);
    if (m_tdata[ERR_LSB +: ERR_W] != want.err)
      report("error_code", m_tdata[ERR_LSB +: ERR_W], want.err);
    if (m_tlast != want.last) report("last_of_run", m_tlast, want.last);
    token_idx++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan       = MODE_IDLE;
      line_no    = 1;
      offset     = '0;
      lex_begin  = '0;
      lex_len    = '0;
      token_idx  = 0;
      mismatches = 0;
      tokens_due.delete();
    end else begin
      // an output taken now always stems from an earlier input
      if (m_tvalid && m_tready) check_token();
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
    end
    outstanding <= tokens_due.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for stack_asm_tokenizer_unit: drives source text with random gaps and stalls
// and gives the verdict. Depends on satok_pkg, stack_asm_tokenizer_unit and tokenizer_checker.
module tb_top;
  import satok_pkg::*;

  localparam int TOK_W = ((TYPE_W + LINE_BITS_DEF + OFFSET_BITS_DEF + LEN_W + ERR_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_BYTES  = 350;
  localparam int NEWLINE_BURST = 40;
  localparam int DRAIN_CYCLES  = 20;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic [7:0]       s_tdata  = '0;
  logic             s_tlast  = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [TOK_W-1:0] m_tdata;
  logic             m_tlast;

  logic steady = 1'b0;     // no gaps and no stalls while set
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   sent = 0;
  int   mismatches;
  int   outstanding;

  string keywords[KW_COUNT] = '{
    "nop", "push", "pop", "add", "sub", "mul", "div", "mod", "dup", "swap", "dup2", "swap2",
    "cmpe", "cmpne", "cmpg", "cmpl", "cmple", "cmpge", "jmp", "jz", "jnz", "print", "halt"
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stack_asm_tokenizer_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  tokenizer_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .mismatches, .outstanding
  );

  // token sink: draws a fresh random stall after every transaction
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      hold = steady ? 0 : $urandom_range(0, 4);
      m_tready   <= (hold == 0);
      stall_left <= hold;
    end else if (!m_tready) begin
      if (stall_left > 1) stall_left <= stall_left - 1;
      else begin
        stall_left <= 0;
        m_tready   <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high from one byte to the next unless a gap is drawn
  task automatic push_byte(input logic [7:0] c, input logic text_end);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= text_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic push_text(input string s, input logic text_end);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], text_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic push_word(input int n, input logic text_end);
    push_byte(pick_letter(), text_end && n == 1);
    for (int i = 1; i < n; i++)
      push_byte(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter(),
                text_end && i == n - 1);
  endtask

  task automatic push_digits(input int n, input logic text_end);
    for (int i = 0; i < n; i++) push_byte(pick_digit(), text_end && i == n - 1);
  endtask

  // stop sending until every predicted token has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int lexeme_size();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
  endfunction

  initial begin
    int         mark;
    int         pick;
    int         n;
    int         m;
    logic       text_end;
    logic [7:0] c;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every keyword, labels, numbers, literals, comments
    foreach (keywords[i]) begin
      push_text(keywords[i], 1'b0);
      push_byte(" ", 1'b0);
    end
    push_text("loop: jz loop\npush: 42 3.14 7. 'a' ''' '\n' #note push\n", 1'b0);
    push_text("NOP Push pushx swap2x h1alt 12.34.5 9abc 77:\n", 1'b0);
    // long lexemes that still fit, up to the maximum length
    push_digits(24, 1'b0);
    push_byte(" ", 1'b0);
    push_word(23, 1'b0);
    push_byte(CH_COLON, 1'b0);
    push_digits(10, 1'b0);
    push_byte(CH_DOT, 1'b0);
    push_digits(13, 1'b0);
    push_byte(CH_NL, 1'b0);
    // bytes that start nothing
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    // end of text in word, number, comment and idle modes, one of them ending two tokens at once
    push_text("halt", 1'b1);
    push_text("x 12a", 1'b1);
    push_text("push 3.", 1'b1);
    push_text("#open", 1'b1);
    push_text("lbl:", 1'b1);
    push_text("'z'", 1'b1);
    push_text("5\n", 1'b1);
    settle();

    // back-to-back newlines, then a comment closed by its newline
    steady <= 1'b1;
    repeat (NEWLINE_BURST) push_byte(CH_NL, 1'b0);
    push_text("halt #x\n7", 1'b1);
    steady <= 1'b0;

    // random well-formed text with some noise
    mark = sent;
    while (sent < mark + RANDOM_BYTES) begin
      pick     = $urandom_range(0, 99);
      text_end = ($urandom_range(0, 19) == 0);
      if (pick < 25) begin
        if ($urandom_range(0, 3) == 0) begin
          push_text(keywords[$urandom_range(0, KW_COUNT - 1)], 1'b0);
          push_byte(CH_COLON, text_end);
        end else begin
          push_text(keywords[$urandom_range(0, KW_COUNT - 1)], text_end);
        end
      end else if (pick < 40) begin
        push_word(lexeme_size(), 1'b0);
        push_byte(CH_COLON, text_end);
      end else if (pick < 50) begin
        push_word(lexeme_size(), text_end);
      end else if (pick < 62) begin
        push_digits(lexeme_size(), text_end);
      end else if (pick < 72) begin
        if ($urandom_range(0, 7) == 0) begin
          n = $urandom_range(1, 23);
          m = 23 - n;
        end else begin
          n = $urandom_range(1, 6);
          m = $urandom_range(0, 6);
        end
        push_digits(n, 1'b0);
        push_byte(CH_DOT, text_end && m == 0);
        if (m > 0) push_digits(m, text_end);
      end else if (pick < 80) begin
        push_byte(CH_QUOTE, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(CH_QUOTE, text_end);
      end else if (pick < 88) begin
        push_byte(CH_HASH, text_end && $urandom_range(0, 1) == 0 ? 1'b0 : 1'b0);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          push_byte(c, text_end && i == n - 1);
        end
        // a comment cut off by the end of text needs no newline
        if (!text_end || n == 0) push_byte(CH_NL, text_end);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        push_byte(c, text_end);
      end
      case ($urandom_range(0, 4))
        0: push_byte(CH_NL, 1'b0);
        1: push_byte(8'h09, 1'b0);
        2: push_byte(",", 1'b0);
        default: push_byte(" ", 1'b0);
      endcase
      if ($urandom_range(0, 29) == 0) steady <= ~steady;
      if ($urandom_range(0, 49) == 0 || sent - mark == RANDOM_BYTES / 2) settle();
    end
    steady <= 1'b0;

    // one error per run, then the unit must stay silent
    settle();
    case ($urandom_range(0, 4))
      0: push_text("'ab", 1'b0);
      1: push_text("x'", 1'b1);
      2: push_text("'z", 1'b1);
      3: push_digits(25, 1'b0);
      default: begin
        push_digits(12, 1'b0);
        push_byte(CH_DOT, 1'b0);
        push_digits(12, 1'b0);
      end
    endcase
    repeat (20) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
